// ----- rtl/c8ie_pkg.sv -----
// Shared types, codes and helper functions for the CHIP-8 instruction execute block.
// Used by every module in rtl/; depends on nothing else.
package c8ie_pkg;

    localparam logic [11:0] START_ADDR_RESET = 12'h200;
    localparam logic [11:0] SYS_CLS          = 12'h0E0;
    localparam logic [11:0] SYS_RET          = 12'h0EE;
    localparam logic [7:0]  MISC_BCD         = 8'h33;
    localparam logic [3:0]  VF_INDEX         = 4'hF;
    localparam logic [3:0]  V0_INDEX         = 4'h0;

    typedef enum logic [3:0] {
        OP_SYS     = 4'h0,
        OP_JP      = 4'h1,
        OP_CALL    = 4'h2,
        OP_SE_IMM  = 4'h3,
        OP_SNE_IMM = 4'h4,
        OP_SE_REG  = 4'h5,
        OP_LD_IMM  = 4'h6,
        OP_ADD_IMM = 4'h7,
        OP_ALU     = 4'h8,
        OP_SNE_REG = 4'h9,
        OP_LD_I    = 4'hA,
        OP_JP_V0   = 4'hB,
        OP_RND     = 4'hC,
        OP_DRAW    = 4'hD,
        OP_KEY     = 4'hE,
        OP_MISC    = 4'hF
    } opcode_t;

    typedef enum logic [3:0] {
        ALU_LD   = 4'h0,
        ALU_OR   = 4'h1,
        ALU_AND  = 4'h2,
        ALU_XOR  = 4'h3,
        ALU_ADD  = 4'h4,
        ALU_SUB  = 4'h5,
        ALU_SHR  = 4'h6,
        ALU_SUBN = 4'h7,
        ALU_SHL  = 4'hE
    } alu_op_t;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVERFLOW  = 2'd1,
        FAULT_UNDERFLOW = 2'd2
    } fault_t;

    typedef struct packed {
        logic       x_en;
        logic [3:0] x_addr;
        logic [7:0] x_data;
        logic       f_en;
        logic [7:0] f_data;
    } rf_wr_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        logic [11:0] push_addr;
    } stk_cmd_t;

    typedef struct packed {
        logic        full;
        logic        empty;
        logic [11:0] top;
    } stk_status_t;

    typedef struct packed {
        logic [1:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        bcd_valid;
        logic [11:0] bcd_address;
        bcd_t        bcd;
        fault_t      stack_fault;
    } result_t;

    function automatic bcd_t to_bcd(input logic [7:0] value);
        bcd_t        d;
        logic [6:0]  rem;
        logic [17:0] prod;
        logic [6:0]  ones_full;
        if (value >= 8'd200)
        begin
            d.hundreds = 2'd2;
            rem        = 7'(value - 8'd200);
        end
        else if (value >= 8'd100)
        begin
            d.hundreds = 2'd1;
            rem        = 7'(value - 8'd100);
        end
        else
        begin
            d.hundreds = 2'd0;
            rem        = value[6:0];
        end
        // Multiplying by 205 and dropping 11 bits divides by ten exactly below 1024.
        prod      = 18'(rem) * 18'd205;
        d.tens    = prod[14:11];
        ones_full = rem - 7'(d.tens) * 7'd10;
        d.ones    = ones_full[3:0];
        return d;
    endfunction

endpackage

// ----- rtl/c8ie_regfile.sv -----
// General register file V0..VF with three read ports and a VX/VF write pair.
// Depends on c8ie_pkg.
module c8ie_regfile
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  c8ie_pkg::rf_wr_t wr,
    input  logic [3:0]       rd_x_addr,
    input  logic [3:0]       rd_y_addr,
    output logic [7:0]       rd_x_data,
    output logic [7:0]       rd_y_data,
    output logic [7:0]       rd_v0_data
);

    logic [7:0] regs_reg [16];

    assign rd_x_data  = regs_reg[rd_x_addr];
    assign rd_y_data  = regs_reg[rd_y_addr];
    assign rd_v0_data = regs_reg[c8ie_pkg::V0_INDEX];

    // The flag write is checked before the result write, so it wins when X is F.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                regs_reg[i] <= 8'd0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (wr.f_en && (4'(i) == c8ie_pkg::VF_INDEX))
                begin
                    regs_reg[i] <= wr.f_data;
                end
                else if (wr.x_en && (wr.x_addr == 4'(i)))
                begin
                    regs_reg[i] <= wr.x_data;
                end
            end
        end
    end

endmodule

// ----- rtl/c8ie_stack.sv -----
// Return address stack with depth counter, full and empty status and top-of-stack read.
// Depends on c8ie_pkg.
module c8ie_stack #(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_en,
    input  c8ie_pkg::stk_cmd_t     cmd,
    output c8ie_pkg::stk_status_t  status
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);

    logic [11:0]   stack_mem [STACK_DEPTH];
    logic [CW-1:0] depth_reg;
    logic [CW-1:0] depth_next;
    logic [CW-1:0] top_ptr;

    assign top_ptr      = depth_reg - CW'(1);
    assign status.full  = (depth_reg == CW'(STACK_DEPTH));
    assign status.empty = (depth_reg == '0);
    assign status.top   = stack_mem[top_ptr[IW-1:0]];

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd_en && cmd.push)
        begin
            depth_next = depth_reg + CW'(1);
        end
        else if (cmd_en && cmd.pop)
        begin
            depth_next = top_ptr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_en && cmd.push)
        begin
            stack_mem[depth_reg[IW-1:0]] <= cmd.push_addr;
        end
    end

endmodule

// ----- rtl/c8ie_exec.sv -----
// Combinational decode and execute of one instruction word.
// Depends on c8ie_pkg.
module c8ie_exec
(
    input  logic [15:0]           word,
    input  logic [7:0]            rnd,
    input  logic [11:0]           pc,
    input  logic [11:0]           index,
    input  logic [7:0]            vx,
    input  logic [7:0]            vy,
    input  logic [7:0]            v0,
    input  c8ie_pkg::stk_status_t stk,
    output c8ie_pkg::rf_wr_t      rf_wr,
    output c8ie_pkg::stk_cmd_t    stk_cmd,
    output logic                  index_wr,
    output logic [11:0]           index_data,
    output c8ie_pkg::result_t     result
);

    logic [3:0]  x_field;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [11:0] pc_plus2;
    logic [11:0] pc_plus4;
    logic [8:0]  alu_sum;
    logic        alu_flag;

    assign x_field  = word[11:8];
    assign nn       = word[7:0];
    assign nnn      = word[11:0];
    assign pc_plus2 = pc + 12'd2;
    assign pc_plus4 = pc + 12'd4;
    assign alu_sum  = 9'(vx) + 9'(vy);

    always_comb
    begin
        rf_wr              = '0;
        rf_wr.x_addr       = x_field;
        stk_cmd            = '0;
        stk_cmd.push_addr  = pc_plus2;
        index_wr           = 1'b0;
        index_data         = nnn;
        result             = '0;
        result.next_pc     = pc_plus2;
        result.stack_fault = c8ie_pkg::FAULT_NONE;
        alu_flag           = 1'b0;

        case (c8ie_pkg::opcode_t'(word[15:12]))
            c8ie_pkg::OP_SYS:
            begin
                if (nnn == c8ie_pkg::SYS_RET)
                begin
                    if (stk.empty)
                    begin
                        result.stack_fault = c8ie_pkg::FAULT_UNDERFLOW;
                    end
                    else
                    begin
                        stk_cmd.pop    = 1'b1;
                        result.next_pc = stk.top;
                    end
                end
                else if (nnn != c8ie_pkg::SYS_CLS)
                begin
                    result.next_pc = nnn;
                end
            end
            c8ie_pkg::OP_JP:
            begin
                result.next_pc = nnn;
            end
            c8ie_pkg::OP_CALL:
            begin
                if (stk.full)
                begin
                    result.stack_fault = c8ie_pkg::FAULT_OVERFLOW;
                end
                else
                begin
                    stk_cmd.push   = 1'b1;
                    result.next_pc = nnn;
                end
            end
            c8ie_pkg::OP_SE_IMM:
            begin
                if (vx == nn)
                begin
                    result.next_pc = pc_plus4;
                end
            end
            c8ie_pkg::OP_SNE_IMM:
            begin
                if (vx != nn)
                begin
                    result.next_pc = pc_plus4;
                end
            end
            c8ie_pkg::OP_SE_REG:
            begin
                if (vx == vy)
                begin
                    result.next_pc = pc_plus4;
                end
            end
            c8ie_pkg::OP_SNE_REG:
            begin
                if (vx != vy)
                begin
                    result.next_pc = pc_plus4;
                end
            end
            c8ie_pkg::OP_LD_IMM:
            begin
                rf_wr.x_en   = 1'b1;
                rf_wr.x_data = nn;
            end
            c8ie_pkg::OP_ADD_IMM:
            begin
                rf_wr.x_en   = 1'b1;
                rf_wr.x_data = vx + nn;
            end
            c8ie_pkg::OP_ALU:
            begin
                case (c8ie_pkg::alu_op_t'(word[3:0]))
                    c8ie_pkg::ALU_LD:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.x_data = vy;
                    end
                    c8ie_pkg::ALU_OR:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.x_data = vx | vy;
                    end
                    c8ie_pkg::ALU_AND:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.x_data = vx & vy;
                    end
                    c8ie_pkg::ALU_XOR:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.x_data = vx ^ vy;
                    end
                    c8ie_pkg::ALU_ADD:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.f_en   = 1'b1;
                        rf_wr.x_data = alu_sum[7:0];
                        alu_flag     = alu_sum[8];
                    end
                    c8ie_pkg::ALU_SUB:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.f_en   = 1'b1;
                        rf_wr.x_data = vx - vy;
                        alu_flag     = (vx >= vy);
                    end
                    c8ie_pkg::ALU_SHR:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.f_en   = 1'b1;
                        rf_wr.x_data = {1'b0, vx[7:1]};
                        alu_flag     = vx[0];
                    end
                    c8ie_pkg::ALU_SUBN:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.f_en   = 1'b1;
                        rf_wr.x_data = vy - vx;
                        alu_flag     = (vy >= vx);
                    end
                    c8ie_pkg::ALU_SHL:
                    begin
                        rf_wr.x_en   = 1'b1;
                        rf_wr.f_en   = 1'b1;
                        rf_wr.x_data = {vx[6:0], 1'b0};
                        alu_flag     = vx[7];
                    end
                    default:
                    begin
                    end
                endcase
                rf_wr.f_data = {7'd0, alu_flag};
            end
            c8ie_pkg::OP_LD_I:
            begin
                index_wr = 1'b1;
            end
            c8ie_pkg::OP_JP_V0:
            begin
                result.next_pc = 12'(v0) + nnn;
            end
            c8ie_pkg::OP_RND:
            begin
                rf_wr.x_en   = 1'b1;
                rf_wr.x_data = rnd & nn;
            end
            c8ie_pkg::OP_MISC:
            begin
                if (nn == c8ie_pkg::MISC_BCD)
                begin
                    result.bcd_valid   = 1'b1;
                    result.bcd_address = index;
                    result.bcd         = c8ie_pkg::to_bcd(vx);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- rtl/chip8_instruction_execute.sv -----
// Top level of the CHIP-8 instruction execute block: request register, state and result register.
// Depends on c8ie_pkg, c8ie_regfile, c8ie_stack and c8ie_exec.
//
// The block executes one CHIP-8 instruction per clock cycle, back to back, unless a waiting
// result stalls it. A request is captured in an input register; the decode and execute logic
// then reads the register file, index register, program counter and top of stack, and the
// result register, the architectural state and the stack are all written at the same edge.
// The throughput of one instruction per cycle is set by that single execute step, which must
// finish before the next instruction can see the state it leaves. The result register
// decouples the two sides: a new request is taken while a finished result waits, but only
// while the input register is empty. After reset the program counter is 0x200; writing
// start_address is stored but does not move a running PC.
module chip8_instruction_execute #(
    parameter int STACK_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] instruction_word,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] next_pc,
    output logic        bcd_valid,
    output logic [11:0] bcd_address,
    output logic [1:0]  bcd_hundreds,
    output logic [3:0]  bcd_tens,
    output logic [3:0]  bcd_ones,
    output logic [1:0]  stack_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    logic                  req_valid_reg;
    logic [15:0]           word_reg;
    logic [7:0]            rnd_reg;
    logic                  out_valid_reg;
    c8ie_pkg::result_t     result_reg;
    logic [11:0]           pc_reg;
    logic [11:0]           index_reg;
    logic [11:0]           start_address_reg;
    logic                  advance;

    logic [7:0]            vx;
    logic [7:0]            vy;
    logic [7:0]            v0;
    c8ie_pkg::rf_wr_t      rf_wr;
    c8ie_pkg::stk_cmd_t    stk_cmd;
    c8ie_pkg::stk_status_t stk_status;
    logic                  index_wr;
    logic [11:0]           index_data;
    c8ie_pkg::result_t     result_next;

    assign advance   = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign next_pc      = result_reg.next_pc;
    assign bcd_valid    = result_reg.bcd_valid;
    assign bcd_address  = result_reg.bcd_address;
    assign bcd_hundreds = result_reg.bcd.hundreds;
    assign bcd_tens     = result_reg.bcd.tens;
    assign bcd_ones     = result_reg.bcd.ones;
    assign stack_fault  = result_reg.stack_fault;

    c8ie_regfile u_regfile
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (advance),
        .wr         (rf_wr),
        .rd_x_addr  (word_reg[11:8]),
        .rd_y_addr  (word_reg[7:4]),
        .rd_x_data  (vx),
        .rd_y_data  (vy),
        .rd_v0_data (v0)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_en (advance),
        .cmd    (stk_cmd),
        .status (stk_status)
    );

    c8ie_exec u_exec
    (
        .word       (word_reg),
        .rnd        (rnd_reg),
        .pc         (pc_reg),
        .index      (index_reg),
        .vx         (vx),
        .vy         (vy),
        .v0         (v0),
        .stk        (stk_status),
        .rf_wr      (rf_wr),
        .stk_cmd    (stk_cmd),
        .index_wr   (index_wr),
        .index_data (index_data),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            pc_reg            <= c8ie_pkg::START_ADDR_RESET;
            index_reg         <= 12'd0;
            start_address_reg <= c8ie_pkg::START_ADDR_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                pc_reg        <= result_next.next_pc;
                if (index_wr)
                begin
                    index_reg <= index_data;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                start_address_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= instruction_word;
            rnd_reg  <= random_byte;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule
